[hdl/rc_pulse_mode_override_mux_top_macros.svh]
// Assertion macros used by the checker of the pulse mode mux.
`ifndef RC_PULSE_MODE_OVERRIDE_MUX_TOP_MACROS_SVH
`define RC_PULSE_MODE_OVERRIDE_MUX_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RCPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RCPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rcpm_pkg.sv]
// Package: types, codes and constants of the pulse mode override mux.
`timescale 1ns / 1ps
`default_nettype none

package rcpm_pkg;

    localparam int TIME_W      = 32;
    localparam int PULSE_W     = 12;
    localparam int BAND_W      = 10;
    localparam int HOLD_W      = 24;
    localparam int STEER_W     = 7;
    localparam int MODE_W      = 3;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;
    localparam int HOST_V_W    = 20;

    // Opcodes carried in the input tuser.
    localparam logic [OP_W-1:0] OP_BUTTON   = 2'd0;
    localparam logic [OP_W-1:0] OP_STEER    = 2'd1;
    localparam logic [OP_W-1:0] OP_THROTTLE = 2'd2;
    localparam logic [OP_W-1:0] OP_HOST     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd3;

    // External mode codes.
    localparam logic [MODE_W-1:0] MODE_LOCK     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HUMAN    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CAL      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OVERRIDE = 3'd4;

    typedef enum logic [4:0] {
        MS_LOCK     = 5'b00001,
        MS_HUMAN    = 5'b00010,
        MS_AUTO     = 5'b00100,
        MS_CAL      = 5'b01000,
        MS_OVERRIDE = 5'b10000
    } mode_state_t;

    // Bit positions of the result fields in the output tdata.
    localparam int OUT_VALID_BIT   = 0;
    localparam int OUT_MODE_LSB    = 1;
    localparam int OUT_SWRITE_BIT  = 4;
    localparam int OUT_SPULSE_LSB  = 5;
    localparam int OUT_TWRITE_BIT  = 17;
    localparam int OUT_TPULSE_LSB  = 18;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic [PULSE_W-1:0] throttle_pulse_us;
        logic               throttle_write;
        logic [PULSE_W-1:0] steer_pulse_us;
        logic               steer_write;
        logic [MODE_W-1:0]  mode;
        logic               width_valid;
    } rcpm_result_t;

    // Button window centres and half width.
    localparam logic [PULSE_W-1:0] BTN_HUMAN_US = 12'd1710;
    localparam logic [PULSE_W-1:0] BTN_LOCK_US  = 12'd1200;
    localparam logic [PULSE_W-1:0] BTN_AUTO_US  = 12'd1000;
    localparam logic [PULSE_W-1:0] BTN_CAL_US   = 12'd888;
    localparam logic [PULSE_W-1:0] BTN_HALF_US  = 12'd50;

    // Reset values.
    localparam logic [PULSE_W-1:0] RST_PULSE_MIN = 12'd500;
    localparam logic [PULSE_W-1:0] RST_PULSE_MAX = 12'd2000;
    localparam logic [BAND_W-1:0]  RST_BAND      = 10'd50;
    localparam logic [HOLD_W-1:0]  RST_HOLD      = 24'd500000;
    localparam logic [PULSE_W-1:0] RST_S_NULL    = 12'd1500;
    localparam logic [PULSE_W-1:0] RST_T_NULL    = 12'd1528;
    localparam logic [PULSE_W-1:0] RST_CAL_MAX   = 12'd1600;
    localparam logic [PULSE_W-1:0] RST_CAL_MIN   = 12'd1400;

    // Host steering scale: percentage centre and fifty steps per span.
    localparam logic [STEER_W-1:0] HOST_CENTRE   = 7'd49;
    localparam logic [STEER_W-1:0] HOST_LOW_BASE = 7'd50;
    localparam logic [5:0]         HOST_SCALE    = 6'd50;
    // Scaled auto steer value held after reset: 1500 * 50.
    localparam logic [HOST_V_W-1:0] RST_HOST_V   = 20'd75000;
    // Division by 50 as multiply by ceil(2^26 / 50), exact for values below 2^20.
    localparam logic [20:0] DIV50_RECIP = 21'd1342178;
    localparam int          DIV50_SHIFT = 26;
    localparam logic [PULSE_W-1:0] PULSE_SAT = 12'd4095;

    function automatic logic [MODE_W-1:0] mode_code(input mode_state_t ms);
        logic [MODE_W-1:0] code;
        case (ms)
            MS_LOCK:     code = MODE_LOCK;
            MS_HUMAN:    code = MODE_HUMAN;
            MS_AUTO:     code = MODE_AUTO;
            MS_CAL:      code = MODE_CAL;
            MS_OVERRIDE: code = MODE_OVERRIDE;
            default:     code = MODE_LOCK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[hdl/rc_pulse_mode_override_mux_top.sv]
// Top level: receiver pulse measurement, mode selection and steering/throttle mux.
// An input item waits in the item register until the result register is empty or being emptied.
// Throughput: one item per cycle while results are taken; the item register and result
// register are the only stages; block state changes as an item moves into the result register.
// Reset (rst_n low, asynchronous) clears both stages, sets lock mode, zero edge times
// and the default calibration, auto steer pulse and configuration values.
`timescale 1ns / 1ps
`default_nettype none

module rc_pulse_mode_override_mux_top
    import rcpm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    // [31:0] time_us, [32] host_enable, [39:33] host_steer
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] opcode
    input  wire logic [OP_W-1:0]        s_axis_tuser,

    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] width_valid, [3:1] mode, [4] steer_write, [16:5] steer_pulse_us,
    // [17] throttle_write, [29:18] throttle_pulse_us, [31:30] zero
    output      logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Item register.
    logic               in_valid_reg;
    logic [OP_W-1:0]    in_op_reg;
    logic [TIME_W-1:0]  in_time_reg;
    logic               in_hen_reg;
    logic [STEER_W-1:0] in_hs_reg;

    // Result register.
    logic               out_valid_reg;
    rcpm_result_t       out_data_reg;

    // Configuration.
    logic [PULSE_W-1:0] pulse_min_reg;
    logic [PULSE_W-1:0] pulse_max_reg;
    logic [BAND_W-1:0]  band_reg;
    logic [HOLD_W-1:0]  hold_reg;

    // Block state and next values.
    mode_state_t          mode_reg, mode_next;
    logic [TIME_W-1:0]    last_edge_reg [3];
    logic [TIME_W-1:0]    last_edge_next [3];
    logic [TIME_W-1:0]    mode_time_reg, mode_time_next;
    logic [PULSE_W-1:0]   steer_width_reg, steer_width_next;
    logic [PULSE_W-1:0]   throttle_width_reg, throttle_width_next;
    logic [PULSE_W-1:0]   s_null_reg, s_null_next;
    logic [PULSE_W-1:0]   s_max_reg, s_max_next;
    logic [PULSE_W-1:0]   s_min_reg, s_min_next;
    logic [PULSE_W-1:0]   t_null_reg, t_null_next;
    logic [PULSE_W-1:0]   t_max_reg, t_max_next;
    logic [PULSE_W-1:0]   t_min_reg, t_min_next;
    // The auto steer pulse is kept as fifty times its value; the divide by
    // fifty sits on the read side so that only one multiply stands in each path.
    logic [HOST_V_W-1:0]  host_v_reg, host_v_next;

    logic                 advance;
    rcpm_result_t         result;

    // Datapath intermediates.
    logic [TIME_W-1:0]    last_sel;
    logic [TIME_W-1:0]    dt;
    logic                 is_edge;
    logic                 width_ok;
    logic [PULSE_W-1:0]   w;
    logic [40:0]          auto_prod;
    logic [14:0]          auto_quot;
    logic [PULSE_W-1:0]   auto_pulse;
    logic [PULSE_W-1:0]   dev;
    logic                 over_band;
    logic [TIME_W-1:0]    since_change;
    logic                 held;
    logic [PULSE_W:0]     avg_sum;
    logic                 host_high;
    logic [STEER_W-1:0]   host_k;
    logic [PULSE_W-1:0]   host_d;
    logic [18:0]          host_prod;
    logic [17:0]          null_x50;
    logic [HOST_V_W-1:0]  host_v;

    function automatic logic in_window(input logic [PULSE_W-1:0] x,
                                       input logic [PULSE_W-1:0] ctr);
        return (x > ctr - BTN_HALF_US) && (x < ctr + BTN_HALF_US);
    endfunction

    // An item moves on when the result register is empty or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(rcpm_result_t)){1'b0}}, out_data_reg};
    assign cfg_ready     = 1'b1;

    // Pulse width since the previous edge on the same channel.
    always_comb
    begin
        case (in_op_reg)
            OP_BUTTON:   last_sel = last_edge_reg[0];
            OP_STEER:    last_sel = last_edge_reg[1];
            OP_THROTTLE: last_sel = last_edge_reg[2];
            default:     last_sel = in_time_reg;
        endcase
    end

    assign is_edge  = (in_op_reg != OP_HOST);
    assign dt       = in_time_reg - last_sel;
    assign width_ok = is_edge && (dt > {20'd0, pulse_min_reg}) && (dt < {20'd0, pulse_max_reg});
    // A valid width lies below the 12-bit upper limit.
    assign w        = dt[PULSE_W-1:0];

    // Auto steer pulse: stored value divided by fifty, saturated to 12 bits.
    assign auto_prod  = host_v_reg * DIV50_RECIP;
    assign auto_quot  = auto_prod[40:DIV50_SHIFT];
    assign auto_pulse = (auto_quot > {3'd0, PULSE_SAT}) ? PULSE_SAT : auto_quot[PULSE_W-1:0];

    // Steering deviation from null and the override return timer.
    assign dev          = (w >= s_null_reg) ? (w - s_null_reg) : (s_null_reg - w);
    assign over_band    = dev > {2'd0, band_reg};
    assign since_change = in_time_reg - mode_time_reg;
    assign held         = since_change > {8'd0, hold_reg};
    assign avg_sum      = {1'b0, auto_pulse} + {1'b0, w};

    // Host steering scaled against the calibration. Calibration keeps
    // min <= null <= max, so both spans are non-negative and so is the result.
    assign host_high = (in_hs_reg >= HOST_CENTRE);
    assign host_k    = host_high ? (in_hs_reg - HOST_CENTRE) : (HOST_LOW_BASE - in_hs_reg);
    assign host_d    = host_high ? (s_max_reg - s_null_reg) : (s_null_reg - s_min_reg);
    assign host_prod = host_k * host_d;
    assign null_x50  = s_null_reg * HOST_SCALE;
    assign host_v    = host_high ? ({2'd0, null_x50} + {1'b0, host_prod})
                                 : ({2'd0, null_x50} - {1'b0, host_prod});

    always_comb
    begin
        mode_next           = mode_reg;
        last_edge_next      = last_edge_reg;
        mode_time_next      = mode_time_reg;
        steer_width_next    = steer_width_reg;
        throttle_width_next = throttle_width_reg;
        s_null_next         = s_null_reg;
        s_max_next          = s_max_reg;
        s_min_next          = s_min_reg;
        t_null_next         = t_null_reg;
        t_max_next          = t_max_reg;
        t_min_next          = t_min_reg;
        host_v_next         = host_v_reg;

        result                   = '0;
        result.width_valid       = width_ok;

        case (in_op_reg)
            OP_BUTTON:   last_edge_next[0] = in_time_reg;
            OP_STEER:    last_edge_next[1] = in_time_reg;
            OP_THROTTLE: last_edge_next[2] = in_time_reg;
            default:     ;
        endcase

        if (!is_edge)
        begin
            if (in_hen_reg)
            begin
                host_v_next = host_v;
            end
        end
        else if (width_ok)
        begin
            case (in_op_reg)
                OP_BUTTON:
                begin
                    if (in_window(w, BTN_HUMAN_US))
                    begin
                        if (mode_reg != MS_HUMAN)
                        begin
                            mode_next      = MS_HUMAN;
                            mode_time_next = in_time_reg;
                        end
                    end
                    else if (in_window(w, BTN_LOCK_US))
                    begin
                        if (mode_reg != MS_LOCK)
                        begin
                            mode_next      = MS_LOCK;
                            mode_time_next = in_time_reg;
                        end
                    end
                    else if (in_window(w, BTN_AUTO_US))
                    begin
                        if (mode_reg != MS_AUTO)
                        begin
                            mode_next      = MS_AUTO;
                            mode_time_next = in_time_reg;
                        end
                    end
                    else if (in_window(w, BTN_CAL_US))
                    begin
                        if (mode_reg != MS_CAL)
                        begin
                            // Entering calibration restarts all three points
                            // from the latest widths.
                            mode_next      = MS_CAL;
                            mode_time_next = in_time_reg;
                            s_null_next    = steer_width_reg;
                            s_max_next     = steer_width_reg;
                            s_min_next     = steer_width_reg;
                            t_null_next    = throttle_width_reg;
                            t_max_next     = throttle_width_reg;
                            t_min_next     = throttle_width_reg;
                        end
                        else
                        begin
                            if (steer_width_reg > s_max_reg)
                            begin
                                s_max_next = steer_width_reg;
                            end
                            if (steer_width_reg < s_min_reg)
                            begin
                                s_min_next = steer_width_reg;
                            end
                            if (throttle_width_reg > t_max_reg)
                            begin
                                t_max_next = throttle_width_reg;
                            end
                            if (throttle_width_reg < t_min_reg)
                            begin
                                t_min_next = throttle_width_reg;
                            end
                        end
                    end
                end
                OP_STEER:
                begin
                    steer_width_next   = w;
                    result.steer_write = 1'b1;
                    case (mode_reg)
                        MS_HUMAN:
                        begin
                            result.steer_pulse_us = w;
                        end
                        MS_OVERRIDE:
                        begin
                            if (!over_band && held)
                            begin
                                mode_next             = MS_AUTO;
                                mode_time_next        = in_time_reg;
                                result.steer_pulse_us = avg_sum[PULSE_W:1];
                            end
                            else
                            begin
                                result.steer_pulse_us = w;
                            end
                        end
                        MS_AUTO:
                        begin
                            if (over_band)
                            begin
                                mode_next             = MS_OVERRIDE;
                                mode_time_next        = in_time_reg;
                                result.steer_pulse_us = w;
                            end
                            else
                            begin
                                result.steer_pulse_us = auto_pulse;
                            end
                        end
                        default:
                        begin
                            result.steer_pulse_us = s_null_reg;
                        end
                    endcase
                end
                default:
                begin
                    throttle_width_next   = w;
                    result.throttle_write = 1'b1;
                    if (mode_reg == MS_HUMAN || mode_reg == MS_AUTO || mode_reg == MS_OVERRIDE)
                    begin
                        result.throttle_pulse_us = w;
                    end
                    else
                    begin
                        result.throttle_pulse_us = t_null_reg;
                    end
                end
            endcase
        end

        result.mode = mode_code(mode_next);
    end

    // Item register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg   <= s_axis_tuser;
            in_time_reg <= s_axis_tdata[TIME_W-1:0];
            in_hen_reg  <= s_axis_tdata[TIME_W];
            in_hs_reg   <= s_axis_tdata[TIME_W+STEER_W:TIME_W+1];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_min_reg <= RST_PULSE_MIN;
            pulse_max_reg <= RST_PULSE_MAX;
            band_reg      <= RST_BAND;
            hold_reg      <= RST_HOLD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PULSE_MIN: pulse_min_reg <= cfg_data[PULSE_W-1:0];
                CFG_PULSE_MAX: pulse_max_reg <= cfg_data[PULSE_W-1:0];
                CFG_BAND:      band_reg      <= cfg_data[BAND_W-1:0];
                CFG_HOLD:      hold_reg      <= cfg_data[HOLD_W-1:0];
                default:       ;
            endcase
        end
    end

    // Block state, updated as each item moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MS_LOCK;
            last_edge_reg[0]   <= '0;
            last_edge_reg[1]   <= '0;
            last_edge_reg[2]   <= '0;
            mode_time_reg      <= '0;
            steer_width_reg    <= '0;
            throttle_width_reg <= '0;
            s_null_reg         <= RST_S_NULL;
            s_max_reg          <= RST_CAL_MAX;
            s_min_reg          <= RST_CAL_MIN;
            t_null_reg         <= RST_T_NULL;
            t_max_reg          <= RST_CAL_MAX;
            t_min_reg          <= RST_CAL_MIN;
            host_v_reg         <= RST_HOST_V;
        end
        else if (advance)
        begin
            mode_reg           <= mode_next;
            last_edge_reg      <= last_edge_next;
            mode_time_reg      <= mode_time_next;
            steer_width_reg    <= steer_width_next;
            throttle_width_reg <= throttle_width_next;
            s_null_reg         <= s_null_next;
            s_max_reg          <= s_max_next;
            s_min_reg          <= s_min_next;
            t_null_reg         <= t_null_next;
            t_max_reg          <= t_max_next;
            t_min_reg          <= t_min_next;
            host_v_reg         <= host_v_next;
        end
    end

endmodule

`default_nettype wire

[hdl/rcpm_checker.sv]
// Port-level checker for the pulse mode mux and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "rc_pulse_mode_override_mux_top_macros.svh"

module rcpm_checker
    import rcpm_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result keeps its place and its value.
    `RCPM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // A result shown after an empty cycle comes from an input transfer through the item register.
    `RCPM_ASSERT_NOW(a_out_latency, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without matching input transfer")

    // The input side only stalls when a result waits to be taken.
    `RCPM_ASSERT_NOW(a_in_backpressure, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled with free result register")

    // A pulse is issued only for a valid width, and never on both channels at once.
    `RCPM_ASSERT_NOW(a_write_flags, m_axis_tvalid && (m_axis_tdata[OUT_SWRITE_BIT] || m_axis_tdata[OUT_TWRITE_BIT]), m_axis_tdata[OUT_VALID_BIT] && !(m_axis_tdata[OUT_SWRITE_BIT] && m_axis_tdata[OUT_TWRITE_BIT]), "pulse issued without a valid width")

endmodule

bind rc_pulse_mode_override_mux_top rcpm_checker u_rcpm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
